>>> hw/rtl/uart_line_settings_divisor_unit_top_macros.svh
// Assertion macros used by the sequencer of the serial line settings unit.
`ifndef UART_LINE_SETTINGS_DIVISOR_UNIT_TOP_MACROS_SVH
`define UART_LINE_SETTINGS_DIVISOR_UNIT_TOP_MACROS_SVH

// Checked while out of reset.
`define ULDU_ASSERT(lbl, clk, rst_n, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ULDU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/uldu_pkg.sv
// Shared types, constants and tables of the serial line settings unit.
package uldu_pkg;

	localparam int CHANNELS_DEFAULT = 4;
	localparam int CLOCK_W = 32;
	localparam int BAUD_W = 20;
	localparam int DIV_STEPS = CLOCK_W;
	localparam int BAUD_COUNT = 21;

	localparam logic [2:0] CMD_WR_BAUD   = 3'd0;
	localparam logic [2:0] CMD_WR_DATA   = 3'd1;
	localparam logic [2:0] CMD_WR_PARITY = 3'd2;
	localparam logic [2:0] CMD_WR_STOP   = 3'd3;
	localparam logic [2:0] CMD_RD_BAUD   = 3'd4;
	localparam logic [2:0] CMD_RD_DATA   = 3'd5;
	localparam logic [2:0] CMD_RD_PARITY = 3'd6;
	localparam logic [2:0] CMD_RD_STOP   = 3'd7;

	localparam logic [4:0] DATA_MAX  = 5'd3;
	localparam logic [4:0] PAR_NONE  = 5'd0;
	localparam logic [4:0] PAR_EVEN  = 5'd1;
	localparam logic [4:0] PAR_ODD   = 5'd2;
	localparam logic [4:0] STOP_ONE  = 5'd0;
	localparam logic [4:0] STOP_TWO  = 5'd2;

	localparam logic [2:0] LCR_PAR_NONE = 3'd0;
	localparam logic [2:0] LCR_PAR_EVEN = 3'd5;
	localparam logic [2:0] LCR_PAR_ODD  = 3'd4;

	typedef struct packed {
		logic [4:0] baud;
		logic [1:0] data;
		logic [1:0] parity;
		logic [1:0] stop;
	} settings_t;

	// 115200 baud, 8 data bits, no parity, one stop bit
	localparam settings_t SETTINGS_RESET = '{baud: 5'd16, data: 2'd3, parity: 2'd0,
		stop: 2'd0};

	typedef struct packed {
		logic load;
		logic early;
		logic div_init;
		logic div_step;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic out_of_range;
		logic is_read;
		logic invalid;
		logic quot_zero;
	} dp_status_t;

	function automatic logic [BAUD_W-1:0] baud_to_hz(input logic [4:0] idx);
		logic [BAUD_W-1:0] r;
		unique case (idx)
			5'd0:  r = 20'd50;
			5'd1:  r = 20'd75;
			5'd2:  r = 20'd110;
			5'd3:  r = 20'd134;
			5'd4:  r = 20'd200;
			5'd5:  r = 20'd300;
			5'd6:  r = 20'd600;
			5'd7:  r = 20'd1200;
			5'd8:  r = 20'd1800;
			5'd9:  r = 20'd2400;
			5'd10: r = 20'd4800;
			5'd11: r = 20'd9600;
			5'd12: r = 20'd19200;
			5'd13: r = 20'd38400;
			5'd14: r = 20'd57600;
			5'd15: r = 20'd76800;
			5'd16: r = 20'd115200;
			5'd17: r = 20'd230400;
			5'd18: r = 20'd380400;
			5'd19: r = 20'd460800;
			5'd20: r = 20'd921600;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] slot_word(input logic [3:0] idx);
		logic [15:0] r;
		unique case (idx)
			4'd0:  r = 16'h0000;
			4'd1:  r = 16'h0080;
			4'd2:  r = 16'h0808;
			4'd3:  r = 16'h0888;
			4'd4:  r = 16'h2222;
			4'd5:  r = 16'h4924;
			4'd6:  r = 16'h4a52;
			4'd7:  r = 16'h54aa;
			4'd8:  r = 16'h5555;
			4'd9:  r = 16'hd555;
			4'd10: r = 16'hd5d5;
			4'd11: r = 16'hddd5;
			4'd12: r = 16'hdddd;
			4'd13: r = 16'hdfdd;
			4'd14: r = 16'hdfdf;
			default: r = 16'hffdf;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/uldu_datapath.sv
// Settings store, validation, clock/baud divider and result registers.
module uldu_datapath #(
	parameter int CHANNELS = uldu_pkg::CHANNELS_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [31:0]          cfg_data,
	input  logic [1:0]           channel,
	input  logic [2:0]           command,
	input  logic [4:0]           field_value,
	input  uldu_pkg::dp_cmd_t    cmd,
	output uldu_pkg::dp_status_t status,
	output logic [1:0]           channel_out,
	output logic [4:0]           read_value,
	output logic [22:0]          divisor,
	output logic [15:0]          slot_pattern,
	output logic [5:0]           line_control,
	output logic                 updated,
	output logic                 error
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	uldu_pkg::settings_t store_q [CHANNELS];
	logic [uldu_pkg::CLOCK_W-1:0] clock_rate_q;

	logic [1:0] ch_q;
	logic [2:0] cmd_q;
	logic [4:0] val_q;

	logic [uldu_pkg::BAUD_W-1:0] baud_q;
	logic [uldu_pkg::BAUD_W-1:0] rem_q;
	logic [uldu_pkg::CLOCK_W-1:0] quo_q;

	logic [IDX_W-1:0] idx;
	uldu_pkg::settings_t entry;
	logic [4:0] w_baud, w_data, w_parity, w_stop;
	logic [4:0] rd_value;
	logic       out_of_range, is_read, invalid;
	logic [uldu_pkg::BAUD_W:0] trial;
	logic       trial_ge;
	logic [uldu_pkg::CLOCK_W-5:0] quot;
	logic [2:0] par_code;

	assign idx = IDX_W'(ch_q);
	assign entry = store_q[idx];
	assign out_of_range = int'(ch_q) >= CHANNELS;
	assign is_read = cmd_q >= uldu_pkg::CMD_RD_BAUD;

	always_comb begin
		w_baud = entry.baud;
		w_data = {3'b000, entry.data};
		w_parity = {3'b000, entry.parity};
		w_stop = {3'b000, entry.stop};
		rd_value = '0;
		unique case (cmd_q)
			uldu_pkg::CMD_WR_BAUD:   w_baud = val_q;
			uldu_pkg::CMD_WR_DATA:   w_data = val_q;
			uldu_pkg::CMD_WR_PARITY: w_parity = val_q;
			uldu_pkg::CMD_WR_STOP:   w_stop = val_q;
			uldu_pkg::CMD_RD_BAUD:   rd_value = entry.baud;
			uldu_pkg::CMD_RD_DATA:   rd_value = {3'b000, entry.data};
			uldu_pkg::CMD_RD_PARITY: rd_value = {3'b000, entry.parity};
			uldu_pkg::CMD_RD_STOP:   rd_value = {3'b000, entry.stop};
		endcase
	end

	assign invalid = (w_baud >= 5'(uldu_pkg::BAUD_COUNT)) || (w_data > uldu_pkg::DATA_MAX)
		|| (w_parity > uldu_pkg::PAR_ODD)
		|| ((w_stop != uldu_pkg::STOP_ONE) && (w_stop != uldu_pkg::STOP_TWO))
		|| (clock_rate_q == '0);

	always_comb begin
		unique case (w_parity)
			uldu_pkg::PAR_EVEN: par_code = uldu_pkg::LCR_PAR_EVEN;
			uldu_pkg::PAR_ODD:  par_code = uldu_pkg::LCR_PAR_ODD;
			default:            par_code = uldu_pkg::LCR_PAR_NONE;
		endcase
	end

	// clock/(16*baud) is floor(clock/baud) >> 4; the low nibble picks the slot word
	assign quot = quo_q[uldu_pkg::CLOCK_W-1:4];
	assign trial = {rem_q, quo_q[uldu_pkg::CLOCK_W-1]};
	assign trial_ge = trial >= {1'b0, baud_q};

	assign status.out_of_range = out_of_range;
	assign status.is_read = is_read;
	assign status.invalid = invalid;
	assign status.quot_zero = (quot == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_rate_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				store_q[i] <= uldu_pkg::SETTINGS_RESET;
			end
		end else begin
			if (cfg_write) begin
				clock_rate_q <= cfg_data;
			end
			if (cmd.finish && !status.quot_zero) begin
				store_q[idx] <= '{baud: w_baud, data: w_data[1:0], parity: w_parity[1:0],
					stop: w_stop[1:0]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q <= channel;
			cmd_q <= command;
			val_q <= field_value;
		end
		if (cmd.div_init) begin
			baud_q <= uldu_pkg::baud_to_hz(w_baud);
			rem_q <= '0;
			quo_q <= clock_rate_q;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? uldu_pkg::BAUD_W'(trial - {1'b0, baud_q})
				: trial[uldu_pkg::BAUD_W-1:0];
			quo_q <= {quo_q[uldu_pkg::CLOCK_W-2:0], trial_ge};
		end
		if (cmd.early) begin
			channel_out <= ch_q;
			read_value <= out_of_range ? 5'd0 : rd_value;
			divisor <= '0;
			slot_pattern <= '0;
			line_control <= '0;
			updated <= 1'b0;
			error <= out_of_range || !is_read;
		end else if (cmd.finish) begin
			channel_out <= ch_q;
			read_value <= '0;
			updated <= !status.quot_zero;
			error <= status.quot_zero;
			if (status.quot_zero) begin
				divisor <= '0;
				slot_pattern <= '0;
				line_control <= '0;
			end else begin
				divisor <= 23'(quot - 1'b1);
				slot_pattern <= uldu_pkg::slot_word(quo_q[3:0]);
				line_control <= {par_code, (w_stop == uldu_pkg::STOP_TWO), w_data[1:0]};
			end
		end
	end

endmodule

>>> hw/rtl/uldu_controller.sv
// Sequencer of the serial line settings unit: check, divide, finish.
`include "uart_line_settings_divisor_unit_top_macros.svh"

module uldu_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  uldu_pkg::dp_status_t status,
	output uldu_pkg::dp_cmd_t    cmd,
	output logic                 busy,
	output logic                 done
);

	localparam int STEP_W = $clog2(uldu_pkg::DIV_STEPS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] cnt_q;
	logic done_q;
	logic early_exit;

	assign early_exit = status.out_of_range || status.is_read || status.invalid;
	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:  cmd.load = start;
			ST_CHECK: begin
				cmd.early = early_exit;
				cmd.div_init = !early_exit;
			end
			ST_DIV:   cmd.div_step = 1'b1;
			ST_FIN:   cmd.finish = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					cnt_q <= '0;
					if (early_exit) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_W'(uldu_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ULDU_ASSERT(a_done_when_idle, clk, arst_n, done_q |-> (state_q == ST_IDLE), "result strobe while busy")
	`ULDU_ASSERT(a_done_single, clk, arst_n, done_q |=> !done_q, "result strobe longer than one cycle")
	`ULDU_ASSERT(a_fin_after_div, clk, arst_n, (state_q == ST_FIN) |-> ($past(state_q) == ST_DIV && $past(cnt_q) == STEP_W'(uldu_pkg::DIV_STEPS - 1)), "finish before all divide steps")
	`ULDU_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> (!done_q && state_q == ST_IDLE), "activity during reset")

endmodule

>>> hw/rtl/uart_line_settings_divisor_unit_top.sv
// Top level of the serial line settings and baud divisor unit.
// Each request (start while busy is low) names a channel, a command and a value and gives
// exactly one result, shown for one cycle with done high; the receiver cannot stall it.
// Reads, requests to a channel out of range, invalid settings and writes with no clock
// finish from the check state. A valid write runs a 32-step restoring division of the
// clock rate by the baud rate, one quotient bit per cycle, then a finish state; the next
// request can start in the cycle the result is shown. The clock rate register may be
// written only while busy is low.
module uart_line_settings_divisor_unit_top #(
	parameter int CHANNELS = uldu_pkg::CHANNELS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  channel,
	input  logic [2:0]  command,
	input  logic [4:0]  field_value,
	output logic        done,
	output logic [1:0]  channel_out,
	output logic [4:0]  read_value,
	output logic [22:0] divisor,
	output logic [15:0] slot_pattern,
	output logic [5:0]  line_control,
	output logic        updated,
	output logic        error
);

	uldu_pkg::dp_cmd_t    dp_cmd;
	uldu_pkg::dp_status_t dp_status;

	uldu_controller u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (dp_status),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	uldu_datapath #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.channel      (channel),
		.command      (command),
		.field_value  (field_value),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.channel_out  (channel_out),
		.read_value   (read_value),
		.divisor      (divisor),
		.slot_pattern (slot_pattern),
		.line_control (line_control),
		.updated      (updated),
		.error        (error)
	);

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the serial line settings and baud divisor unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH = 4;
	localparam int DRAIN_CYCLES = 40;

	localparam int unsigned BAUD_HZ [21] = '{
		50, 75, 110, 134, 200, 300, 600, 1200, 1800, 2400, 4800,
		9600, 19200, 38400, 57600, 76800, 115200, 230400, 380400, 460800, 921600
	};
	localparam logic [15:0] FRAC_SLOTS [16] = '{
		16'h0000, 16'h0080, 16'h0808, 16'h0888, 16'h2222, 16'h4924, 16'h4a52, 16'h54aa,
		16'h5555, 16'hd555, 16'hd5d5, 16'hddd5, 16'hdddd, 16'hdfdd, 16'hdfdf, 16'hffdf
	};

	typedef struct packed {
		logic [1:0] channel;
		logic [2:0] command;
		logic [4:0] value;
	} line_req_t;

	typedef struct packed {
		logic [1:0]  channel;
		logic [4:0]  read_value;
		logic [22:0] divisor;
		logic [15:0] slot;
		logic [5:0]  lcr;
		logic        updated;
		logic        error;
	} line_result_t;

	// full 5-bit fields so a rejected value can sit in the working copy
	typedef struct packed {
		logic [4:0] baud;
		logic [4:0] data;
		logic [4:0] parity;
		logic [4:0] stop;
	} line_cfg_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [31:0] cfg_data = '0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  channel = '0;
	logic [2:0]  command = '0;
	logic [4:0]  field_value = '0;
	logic        done;
	logic [1:0]  channel_out;
	logic [4:0]  read_value;
	logic [22:0] divisor;
	logic [15:0] slot_pattern;
	logic [5:0]  line_control;
	logic        updated;
	logic        error;

	line_req_t    request_q[$];
	line_result_t expected_results[$];
	line_cfg_t    line_store [NUM_CH];
	logic [31:0]  rate_hz;
	logic         took = 1'b0;
	int unsigned  fail_count = 0;
	int unsigned  burst_left = 0;
	int unsigned  gap_left = 0;

	uart_line_settings_divisor_unit_top #(.CHANNELS(NUM_CH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.channel(channel),
		.command(command),
		.field_value(field_value),
		.done(done),
		.channel_out(channel_out),
		.read_value(read_value),
		.divisor(divisor),
		.slot_pattern(slot_pattern),
		.line_control(line_control),
		.updated(updated),
		.error(error)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Applies one request to the local copy of the settings and returns its result.
	function automatic line_result_t predict_line_result(line_req_t rq);
		line_result_t res;
		line_cfg_t    w;
		int unsigned  rate, span, quot, rem;
		logic [2:0]   pcode;
		res = '0;
		res.channel = rq.channel;
		if (int'(rq.channel) >= NUM_CH) begin
			res.error = 1'b1;
			return res;
		end
		w = line_store[rq.channel];
		if (rq.command >= uldu_pkg::CMD_RD_BAUD) begin
			case (rq.command)
				uldu_pkg::CMD_RD_BAUD:   res.read_value = w.baud;
				uldu_pkg::CMD_RD_DATA:   res.read_value = w.data;
				uldu_pkg::CMD_RD_PARITY: res.read_value = w.parity;
				default:                 res.read_value = w.stop;
			endcase
			return res;
		end
		case (rq.command)
			uldu_pkg::CMD_WR_BAUD:   w.baud = rq.value;
			uldu_pkg::CMD_WR_DATA:   w.data = rq.value;
			uldu_pkg::CMD_WR_PARITY: w.parity = rq.value;
			default:                 w.stop = rq.value;
		endcase
		if (w.baud >= uldu_pkg::BAUD_COUNT || w.data > uldu_pkg::DATA_MAX ||
				w.parity > uldu_pkg::PAR_ODD ||
				(w.stop != uldu_pkg::STOP_ONE && w.stop != uldu_pkg::STOP_TWO) ||
				rate_hz == 0) begin
			res.error = 1'b1;
			return res;
		end
		rate = BAUD_HZ[w.baud];
		span = rate * 16;
		quot = rate_hz / span;
		if (quot == 0) begin
			res.error = 1'b1;
			return res;
		end
		rem = rate_hz % span;
		pcode = (w.parity == uldu_pkg::PAR_NONE) ? uldu_pkg::LCR_PAR_NONE :
			(w.parity == uldu_pkg::PAR_EVEN) ? uldu_pkg::LCR_PAR_EVEN : uldu_pkg::LCR_PAR_ODD;
		line_store[rq.channel] = w;
		res.divisor = 23'(quot - 1);
		res.slot = FRAC_SLOTS[4'(rem / rate)];
		res.lcr = {pcode, w.stop == uldu_pkg::STOP_TWO, w.data[1:0]};
		res.updated = 1'b1;
		return res;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Request driver: bursts of random length separated by random gaps.
	always @(negedge clk) begin : drive_requests
		line_req_t rq;
		if (arst_n && (!start || took)) begin
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (request_q.size() != 0) begin
				rq = request_q.pop_front();
				channel <= rq.channel;
				command <= rq.command;
				field_value <= rq.value;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Result monitor and predictor hookup.
	always @(posedge clk) begin : watch_results
		line_result_t want;
		line_req_t    rq;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result on channel %0d with no request waiting", channel_out);
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("channel_out", 32'(want.channel), 32'(channel_out));
					compare_field("read_value", 32'(want.read_value), 32'(read_value));
					compare_field("divisor", 32'(want.divisor), 32'(divisor));
					compare_field("slot_pattern", 32'(want.slot), 32'(slot_pattern));
					compare_field("line_control", 32'(want.lcr), 32'(line_control));
					compare_field("updated", 32'(want.updated), 32'(updated));
					compare_field("error", 32'(want.error), 32'(error));
				end
			end
			if (start && !busy) begin
				rq = '{channel: channel, command: command, value: field_value};
				expected_results.push_back(predict_line_result(rq));
			end
		end else begin
			took <= 1'b0;
		end
	end

	task automatic push_req(input logic [1:0] ch, input logic [2:0] cmd, input logic [4:0] val);
		request_q.push_back('{channel: ch, command: cmd, value: val});
	endtask

	task automatic wait_idle();
		while (request_q.size() != 0 || start || busy || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_clock_rate(input logic [31:0] hz);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_data <= hz;
		@(negedge clk);
		cfg_write <= 1'b0;
		rate_hz = hz;
	endtask

	// Mostly well-formed writes, some reads, the rest raw noise.
	function automatic line_req_t random_request();
		line_req_t rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		rq.channel = 2'($urandom_range(0, 3));
		if (pick < 60) begin
			rq.command = 3'($urandom_range(0, 3));
			case (rq.command)
				uldu_pkg::CMD_WR_BAUD:
					rq.value = 5'($urandom_range(0, uldu_pkg::BAUD_COUNT - 1));
				uldu_pkg::CMD_WR_DATA:   rq.value = 5'($urandom_range(0, 3));
				uldu_pkg::CMD_WR_PARITY: rq.value = 5'($urandom_range(0, 2));
				default: rq.value = $urandom_range(0, 1) ? uldu_pkg::STOP_TWO : uldu_pkg::STOP_ONE;
			endcase
		end else if (pick < 80) begin
			rq.command = 3'($urandom_range(4, 7));
			rq.value = 5'($urandom_range(0, 31));
		end else begin
			rq.command = 3'($urandom_range(0, 7));
			rq.value = 5'($urandom_range(0, 31));
		end
		return rq;
	endfunction

	initial begin : stimulus
		logic [31:0] rates [10];
		for (int i = 0; i < NUM_CH; i++)
			line_store[i] = '{baud: 5'd16, data: 5'd3, parity: 5'd0, stop: 5'd0};
		rate_hz = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// clock still unset: reset values readable, writes rejected
		push_req(2'd0, uldu_pkg::CMD_RD_BAUD, 5'd0);
		push_req(2'd0, uldu_pkg::CMD_RD_DATA, 5'd31);
		push_req(2'd0, uldu_pkg::CMD_RD_PARITY, 5'd0);
		push_req(2'd3, uldu_pkg::CMD_RD_STOP, 5'd0);
		push_req(2'd1, uldu_pkg::CMD_WR_BAUD, 5'd5);
		push_req(2'd2, uldu_pkg::CMD_WR_STOP, 5'd0);

		set_clock_rate(32'd1843200);
		push_req(2'd0, uldu_pkg::CMD_WR_BAUD, 5'd0);
		push_req(2'd0, uldu_pkg::CMD_WR_BAUD, 5'd20);
		push_req(2'd0, uldu_pkg::CMD_WR_BAUD, 5'd21);
		push_req(2'd0, uldu_pkg::CMD_WR_BAUD, 5'd31);
		push_req(2'd0, uldu_pkg::CMD_WR_DATA, 5'd0);
		push_req(2'd0, uldu_pkg::CMD_WR_DATA, 5'd4);
		push_req(2'd0, uldu_pkg::CMD_WR_PARITY, 5'd1);
		push_req(2'd0, uldu_pkg::CMD_WR_PARITY, 5'd2);
		push_req(2'd0, uldu_pkg::CMD_WR_PARITY, 5'd3);
		push_req(2'd0, uldu_pkg::CMD_WR_STOP, 5'd2);
		push_req(2'd0, uldu_pkg::CMD_WR_STOP, 5'd1);
		push_req(2'd0, uldu_pkg::CMD_WR_STOP, 5'd31);
		push_req(2'd0, uldu_pkg::CMD_RD_BAUD, 5'd0);
		push_req(2'd0, uldu_pkg::CMD_RD_STOP, 5'd0);

		// one hertz: every write hits a zero quotient
		set_clock_rate(32'd1);
		push_req(2'd1, uldu_pkg::CMD_WR_DATA, 5'd2);

		set_clock_rate(32'hffff_ffff);
		push_req(2'd3, uldu_pkg::CMD_WR_BAUD, 5'd0);
		push_req(2'd3, uldu_pkg::CMD_WR_BAUD, 5'd20);
		push_req(2'd3, uldu_pkg::CMD_WR_DATA, 5'd3);

		rates = '{32'd0, 32'hffff_ffff, 32'd1, 32'd1843200, 32'd48000000, 32'd100000000,
			32'd14400, $urandom, $urandom_range(800, 2000000), 32'd3686400};
		foreach (rates[p]) begin
			set_clock_rate(rates[p]);
			repeat (105) request_q.push_back(random_request());
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
